// File: sv/box_frustum_cull_test_macros.svh
// Assertion helpers for the box cull block.
`ifndef BOX_FRUSTUM_CULL_TEST_MACROS_SVH
`define BOX_FRUSTUM_CULL_TEST_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BFCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BFCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bfct_pkg.sv
package bfct_pkg;

  localparam int PLANE_COUNT = 6;

  localparam int PIDX_W  = 3;
  localparam int NORM_W  = 18;
  localparam int COORD_W = 32;
  localparam int PROD_W  = NORM_W + COORD_W;   // Q17.32 product
  localparam int SUM_W   = 53;                 // three products plus scaled offset
  localparam int OFF_SH  = 16;                 // Q16.16 offset to Q16.32
  localparam int IN_W    = 288;
  localparam int OUT_W   = 8;

  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [PIDX_W-1:0]         pidx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } opcode_t;

  typedef struct packed {
    norm_t  nx;
    norm_t  ny;
    norm_t  nz;
    coord_t off;
  } plane_t;

  // Input tdata layout, last field listed in the lowest bits.
  typedef struct packed {
    logic [IN_W-281-1:0] pad;
    coord_t box_max_z;
    coord_t box_max_y;
    coord_t box_max_x;
    coord_t box_min_z;
    coord_t box_min_y;
    coord_t box_min_x;
    coord_t plane_offset;
    norm_t  normal_z;
    norm_t  normal_y;
    norm_t  normal_x;
    pidx_t  plane_index;
  } in_item_t;

  // Per-plane products: lo = n*min, hi = n*max, axis 0..2 = x, y, z.
  typedef struct packed {
    prod_t [2:0] lo;
    prod_t [2:0] hi;
    coord_t      off;
  } plane_prod_t;

  function automatic norm_t plane_norm(plane_t p, logic [1:0] axis);
    norm_t n;
    case (axis)
      2'd0: n = p.nx;
      2'd1: n = p.ny;
      2'd2: n = p.nz;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// File: sv/bfct_plane_store.sv
module bfct_plane_store (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          we,
  input  bfct_pkg::pidx_t                               idx,
  input  bfct_pkg::plane_t                              wdata,
  output bfct_pkg::plane_t [bfct_pkg::PLANE_COUNT-1:0] planes
);
  import bfct_pkg::*;

  // Slots past PLANE_COUNT match no entry, so such loads drop out.
  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (we && idx == PIDX_W'(i)) begin
          planes[i] <= wdata;
        end
      end
    end
  end

endmodule

// File: sv/bfct_product.sv
module bfct_product (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  bfct_pkg::in_item_t                                item,
  input  bfct_pkg::plane_t [bfct_pkg::PLANE_COUNT-1:0]     planes,
  input  logic                                              down_ready,
  output logic                                              out_valid,
  output logic                                              up_ready,
  output bfct_pkg::plane_prod_t [bfct_pkg::PLANE_COUNT-1:0] prods
);
  import bfct_pkg::*;

  coord_t mn [3];
  coord_t mx [3];

  assign mn[0] = item.box_min_x;
  assign mn[1] = item.box_min_y;
  assign mn[2] = item.box_min_z;
  assign mx[0] = item.box_max_x;
  assign mx[1] = item.box_max_y;
  assign mx[2] = item.box_max_z;

  assign up_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  // One 18x32 multiplier per corner coordinate, per axis, per plane.
  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < 3; a++) begin
          prods[p].lo[a] <= plane_norm(planes[p], 2'(a)) * mn[a];
          prods[p].hi[a] <= plane_norm(planes[p], 2'(a)) * mx[a];
        end
        prods[p].off <= planes[p].off;
      end
    end
  end

endmodule

// File: sv/bfct_reduce.sv
module bfct_reduce (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  bfct_pkg::plane_prod_t [bfct_pkg::PLANE_COUNT-1:0] prods,
  output logic                                              up_ready,
  input  logic                                              out_ready,
  output logic                                              out_valid,
  output logic                                              visible
);
  import bfct_pkg::*;

  logic   v2;
  logic   v3;
  logic   en2;
  logic   en3;
  logic   en_o;
  prod_t  peak [PLANE_COUNT][3];
  coord_t off2 [PLANE_COUNT];
  sum_t   sa   [PLANE_COUNT];
  sum_t   sb   [PLANE_COUNT];
  logic   visible_next;

  assign en_o     = !out_valid || out_ready;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign up_ready = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2)  v2        <= in_valid;
      if (en3)  v3        <= v2;
      if (en_o) out_valid <= v3;
    end
  end

  // Farthest corner per axis: the larger of n*min and n*max.
  always_ff @(posedge clk) begin
    if (en2 && in_valid) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < 3; a++) begin
          peak[p][a] <= ($signed(prods[p].lo[a]) > $signed(prods[p].hi[a])) ?
                        prods[p].lo[a] : prods[p].hi[a];
        end
        off2[p] <= prods[p].off;
      end
    end
  end

  // Two partial sums per plane.
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        sa[p] <= (SUM_W'(off2[p]) <<< OFF_SH) + SUM_W'(peak[p][0]);
        sb[p] <= SUM_W'(peak[p][1]) + SUM_W'(peak[p][2]);
      end
    end
  end

  // Culled if the farthest corner is still outside any plane.
  always_comb begin
    sum_t total;
    visible_next = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      total = sa[p] + sb[p];
      if (total[SUM_W-1]) visible_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v3) begin
      visible <= visible_next;
    end
  end

endmodule

// File: sv/box_frustum_cull_test.sv
// Channel   | Direction | Signals                              | Transaction
// ----------+-----------+--------------------------------------+-----------------------------
// s_axis    | in        | tvalid, tready, tdata[287:0], tuser  | one plane load or box test
// m_axis    | out       | tvalid, tready, tdata[7:0]           | one visibility result
//
// One item per cycle while m_axis is not stalled; a box test result passes the multiply, peak select
// and partial sum registers, then the final sum into the output register.
// Plane loads write the store at acceptance and produce no result; a test sees
// every load accepted before it.
// Synchronous active-high reset clears the plane store (all zero, never culls)
// and all stage valid bits.
// Stages advance independently: bubbles collapse, and a stalled m_axis holds
// every filled stage; s_axis_tready drops only once all stages are full.
module box_frustum_cull_test (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: plane_index[3], normal_x[18], normal_y[18], normal_z[18],
  // plane_offset[32], box_min_x/y/z[32 each], box_max_x/y/z[32 each], zero pad[7]
  input  logic [287:0] s_axis_tdata,
  // tuser: opcode[1] (0 load plane, 1 test box)
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: visible[1], zero pad[7]
  output logic [7:0]   m_axis_tdata
);
  import bfct_pkg::*;

  in_item_t                     item;
  opcode_t                      op;
  logic                         acc;
  logic                         acc_test;
  logic                         load_we;
  plane_t                       wplane;
  plane_t      [PLANE_COUNT-1:0] planes;
  plane_prod_t [PLANE_COUNT-1:0] prods;
  logic                         p_valid;
  logic                         r_ready;
  logic                         visible;

  assign item     = in_item_t'(s_axis_tdata);
  assign op       = opcode_t'(s_axis_tuser[0]);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign acc_test = acc && op == OP_TEST;
  assign load_we  = acc && op == OP_LOAD;

  assign wplane.nx  = item.normal_x;
  assign wplane.ny  = item.normal_y;
  assign wplane.nz  = item.normal_z;
  assign wplane.off = item.plane_offset;

  bfct_plane_store u_store (
    .clk    (clk),
    .rst    (rst),
    .we     (load_we),
    .idx    (item.plane_index),
    .wdata  (wplane),
    .planes (planes)
  );

  // Stage 1: corner products against the planes as they stand at acceptance.
  bfct_product u_product (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (acc_test),
    .item       (item),
    .planes     (planes),
    .down_ready (r_ready),
    .out_valid  (p_valid),
    .up_ready   (s_axis_tready),
    .prods      (prods)
  );

  // Stages 2 to 4: peaks, sums, sign test, output register.
  bfct_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .prods     (prods),
    .up_ready  (r_ready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .visible   (visible)
  );

  assign m_axis_tdata = {{(OUT_W-1){1'b0}}, visible};

`include "box_frustum_cull_test_macros.svh"

  // A draining output never blocks the input side.
  `BFCT_ASSERT_IMP(a_ready_follows, m_axis_tready, s_axis_tready, "input stalled with output draining")
  // With the output draining, a test result passes every stage through to m_axis.
  `BFCT_ASSERT_NXT(a_test_latency, acc_test ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid, "box test result missing")

endmodule

// File: tb/box_cull_monitor.sv
`timescale 1ns / 100ps

// Watches both streams, keeps its own copy of the plane store and checks
// every visibility result in order.
module box_cull_monitor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           mismatch_count,
  output int           outstanding
);
  import bfct_pkg::*;

  plane_t   planes [PLANE_COUNT];
  logic     visible_q [$];
  in_item_t item_seen;
  logic     want;
  int       fails = 0;

  // Larger of n*lo and n*hi: this axis's share of the farthest corner.
  function automatic longint axis_far(longint n, longint lo, longint hi);
    longint a;
    longint b;
    a = n * lo;
    b = n * hi;
    return (a > b) ? a : b;
  endfunction

  // Box is culled when the farthest corner of some plane is still behind it.
  function automatic logic box_visible(in_item_t it);
    longint reach;
    logic   vis;
    int     p;
    vis = 1'b1;
    for (p = 0; p < PLANE_COUNT; p++) begin
      reach = longint'(planes[p].off) * 65536;
      reach += axis_far(planes[p].nx, it.box_min_x, it.box_max_x);
      reach += axis_far(planes[p].ny, it.box_min_y, it.box_max_y);
      reach += axis_far(planes[p].nz, it.box_min_z, it.box_max_z);
      if (reach < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) planes[i] = '0;
      visible_q.delete();
      outstanding <= 0;
    end else begin
      // results first: one finishing now always belongs to an older test
      if (m_axis_tvalid && m_axis_tready) begin
        if (visible_q.size() == 0) begin
          $error("visible: no result expected, actual %0d", m_axis_tdata[0]);
          fails++;
        end else begin
          want = visible_q.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $error("visible: expected %0d, actual %0d", want, m_axis_tdata[0]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_seen = s_axis_tdata;
        if (opcode_t'(s_axis_tuser[0]) == OP_LOAD) begin
          // slots past the end are dropped
          if (item_seen.plane_index < PLANE_COUNT) begin
            planes[item_seen.plane_index].nx  = item_seen.normal_x;
            planes[item_seen.plane_index].ny  = item_seen.normal_y;
            planes[item_seen.plane_index].nz  = item_seen.normal_z;
            planes[item_seen.plane_index].off = item_seen.plane_offset;
          end
        end else begin
          visible_q.push_back(box_visible(item_seen));
        end
      end
      outstanding <= visible_q.size();
    end
    mismatch_count <= fails;
  end

endmodule

// File: tb/box_frustum_cull_test_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the box cull block. Checking lives in
// box_cull_monitor; this module only drives transactions and decides
// pass or fail.
module box_frustum_cull_test_tb;
  import bfct_pkg::*;

  localparam int     RANDOM_ITEMS = 1430;
  localparam int     WATCHDOG     = 2000;  // cycles with no transaction at all
  localparam int     DRAIN        = 12;    // result latency plus margin
  localparam int     HOLD_AT      = 800;   // result count that starts the long stall
  localparam int     HOLD_CYCLES  = 200;
  localparam coord_t CMIN    = 32'sh8000_0000;
  localparam coord_t CMAX    = 32'sh7fff_ffff;
  localparam coord_t UNIT    = 32'sd65536;     // 1.0 in Q16.16
  localparam norm_t  ONE     = 18'sd65536;     // 1.0 in Q1.16
  localparam norm_t  NEG_ONE = -18'sd65536;
  localparam norm_t  NMAX    = 18'sh1ffff;     // outside +-1.0, still used as given
  localparam norm_t  NMIN    = 18'sh20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  int           mismatch_count;
  int           outstanding;

  // idle odds in percent, changed per phase by the stimulus process
  int send_idle_pct = 38;
  int recv_idle_pct = 59;

  always #6 clk = ~clk;

  box_frustum_cull_test u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  box_cull_monitor u_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Every field but the pad random; the opcode decides which ones the block looks at,
  // so the unused ones still toggle.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.pad          = '0;
    it.plane_index  = PIDX_W'($urandom);
    it.normal_x     = NORM_W'($urandom);
    it.normal_y     = NORM_W'($urandom);
    it.normal_z     = NORM_W'($urandom);
    it.plane_offset = $urandom;
    it.box_min_x    = $urandom;
    it.box_min_y    = $urandom;
    it.box_min_z    = $urandom;
    it.box_max_x    = $urandom;
    it.box_max_y    = $urandom;
    it.box_max_z    = $urandom;
    return it;
  endfunction

  function automatic in_item_t plane_item(int idx, norm_t nx, norm_t ny, norm_t nz,
                                          coord_t off);
    in_item_t it;
    it = noise_item();
    it.plane_index  = PIDX_W'(idx);
    it.normal_x     = nx;
    it.normal_y     = ny;
    it.normal_z     = nz;
    it.plane_offset = off;
    return it;
  endfunction

  function automatic in_item_t box_item(coord_t x0, coord_t y0, coord_t z0,
                                        coord_t x1, coord_t y1, coord_t z1);
    in_item_t it;
    it = noise_item();
    it.box_min_x = x0;
    it.box_min_y = y0;
    it.box_min_z = z0;
    it.box_max_x = x1;
    it.box_max_y = y1;
    it.box_max_z = z1;
    return it;
  endfunction

  // Plane loads: mostly axis-aligned or in-range normals, some raw 18-bit
  // values; offsets lean positive so the origin tends to sit inside.
  // One load in ten aims at a slot that does not exist.
  function automatic in_item_t random_plane_item();
    norm_t  n [3];
    coord_t off;
    int     idx;
    int     mode;
    int     a;
    mode = $urandom_range(99);
    for (a = 0; a < 3; a++) begin
      if (mode < 40)      n[a] = '0;
      else if (mode < 85) n[a] = NORM_W'(span(-65536, 65536));
      else                n[a] = NORM_W'($urandom);
    end
    if (mode < 40) n[$urandom_range(2)] = $urandom_range(1) ? ONE : NEG_ONE;
    if ($urandom_range(99) < 15) off = $urandom;
    else                         off = span(-(1 << 23), (1 << 24) + (1 << 23));
    if ($urandom_range(99) < 90) idx = $urandom_range(5);
    else                         idx = $urandom_range(7, 6);
    return plane_item(idx, n[0], n[1], n[2], off);
  endfunction

  // Boxes around the origin with sizes skewed small; a few inverted ones
  // and a few with raw 32-bit corners.
  function automatic in_item_t random_box_item();
    coord_t lo [3];
    coord_t hi [3];
    coord_t mid;
    coord_t ext;
    int     mode;
    int     a;
    mode = $urandom_range(99);
    for (a = 0; a < 3; a++) begin
      if (mode < 5) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        mid = span(-(1 << 24), 1 << 24);
        ext = $urandom_range(1 << $urandom_range(22));
        lo[a] = mid - ext;
        hi[a] = mid + ext;
        if (mode < 13) begin
          lo[a] = mid + ext;
          hi[a] = mid - ext;
        end
      end
    end
    return box_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // One transaction on s_axis, with random idle cycles ahead of it.
  // tvalid is only lowered in a cycle where it is not raised again.
  task automatic offer(input opcode_t op, input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= it;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Result side: random stalls, plus one long stall once enough results
  // have passed so the pipeline fills and back-pressures the input.
  initial begin
    int taken;
    taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) taken++;
      if (taken == HOLD_AT) begin
        taken++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store never culls, even for extreme and inverted boxes.
    offer(OP_TEST, box_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    offer(OP_TEST, box_item(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    // plane 0 keeps x >= 0
    offer(OP_LOAD, plane_item(0, ONE, '0, '0, '0));
    offer(OP_TEST, box_item(-10 * UNIT, 0, 0, -UNIT, UNIT, UNIT));      // culled
    offer(OP_TEST, box_item(-10 * UNIT, 0, 0, 0, UNIT, UNIT));          // touches plane
    offer(OP_TEST, box_item(5 * UNIT, 0, 0, -5 * UNIT, UNIT, UNIT));    // inverted, visible
    offer(OP_TEST, box_item(-3 * UNIT, 0, 0, -7 * UNIT, UNIT, UNIT));   // inverted, culled
    // loads to missing slots must not land anywhere
    offer(OP_LOAD, plane_item(6, ONE, '0, '0, CMIN));
    offer(OP_LOAD, plane_item(7, NEG_ONE, NEG_ONE, NEG_ONE, CMIN));
    offer(OP_TEST, box_item(0, 0, 0, 0, 0, 0));
    // most negative offset: exactly on the plane at z = CMIN, behind just past it
    offer(OP_LOAD, plane_item(2, '0, '0, NEG_ONE, CMIN));
    offer(OP_TEST, box_item(0, 0, CMIN, UNIT, UNIT, 0));
    offer(OP_TEST, box_item(0, 0, CMIN + 1, UNIT, UNIT, 0));
    offer(OP_LOAD, plane_item(2, '0, '0, '0, '0));
    offer(OP_LOAD, plane_item(0, '0, '0, '0, '0));
    // normals at the 18-bit extremes with extreme offsets and corners
    offer(OP_LOAD, plane_item(5, NMAX, NMIN, ONE, CMAX));
    offer(OP_LOAD, plane_item(3, NMIN, NMIN, NMIN, CMIN));
    offer(OP_TEST, box_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    offer(OP_TEST, box_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    offer(OP_TEST, box_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    // one LSB behind a diagonal plane through the origin
    offer(OP_LOAD, plane_item(4, ONE, ONE, ONE, '0));
    offer(OP_TEST, box_item(-1, -1, -1, -1, -1, -1));

    // Random traffic in three idling phases.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        // sender goes quiet until every result is back, then roles swap
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        send_idle_pct = 59;
        recv_idle_pct = 38;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(99) < 15) offer(OP_LOAD, random_plane_item());
      else                         offer(OP_TEST, random_box_item());
    end

    // Drain, then give stray results a chance to show up.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/bfct_pkg.sv
sv/bfct_plane_store.sv
sv/bfct_product.sv
sv/bfct_reduce.sv
sv/box_frustum_cull_test.sv
tb/box_cull_monitor.sv
tb/box_frustum_cull_test_tb.sv
